@@ src/xkb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xkb_pkg
// Shared constants, item types and codes for the xor k-bucket routing table.
// ---------------------------------------------------------------------------
package xkb_pkg;

    localparam int BUCKET_SIZE = 16;
    localparam int NUM_BUCKETS = 256;
    localparam int SLOT_W      = $clog2(BUCKET_SIZE);
    localparam int CNT_W       = $clog2(BUCKET_SIZE + 1);
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int ADDR_W      = BKT_W + SLOT_W;
    localparam int WORD_W      = 64;
    localparam int ID_W        = 4 * WORD_W;
    localparam int CHK_W       = 32;
    localparam int STAMP_W     = 64;
    localparam int MAIN_W      = 2 * ID_W + CHK_W;
    localparam int SPARE_W     = MAIN_W + STAMP_W;
    localparam int CREC_W      = 2 * CNT_W;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_FIND   = 3'd2,
        OP_ALIVE  = 3'd3,
        OP_DEAD   = 3'd4,
        OP_LIST   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_FALSE   = 3'd0,
        ST_TRUE    = 3'd1,
        ST_ADDED   = 3'd2,
        ST_UPDATED = 3'd3,
        ST_REPL    = 3'd4,
        ST_SELF    = 3'd5
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    key;
        logic [ID_W-1:0]    rad;
        logic [CHK_W-1:0]   chk;
        logic [BKT_W-1:0]   bkt;
        logic [BKT_W-1:0]   ld;
        logic               self_id;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    rad;
        logic [CHK_W-1:0]   chk;
    } t_ment;

    typedef struct packed {
        t_ment              e;
        logic [STAMP_W-1:0] st;
    } t_sent;

    typedef struct packed {
        t_status            status;
        logic               inrep;
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    rad;
        logic [CHK_W-1:0]   chk;
        logic               last;
    } t_res;

    typedef enum logic [4:0] {
        B_IDLE, B_CNT, B_LRD, B_LOUT, B_MRD, B_MCMP, B_MSH_RD, B_MSH_WR,
        B_SRD, B_SCMP, B_PRD, B_PWR, B_SSH_RD, B_SSH_WR, B_CWR, B_OUT
    } t_bst;

endpackage

@@ src/xkb_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xkb_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module xkb_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_wa,
    input  logic [W-1:0]         i_wd,
    input  logic [$clog2(D)-1:0] i_ra,
    output logic [W-1:0]         o_rd
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end

endmodule

@@ src/xkb_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xkb_front
// Takes items, holds the local id and finds the bucket of each key.
// ---------------------------------------------------------------------------
module xkb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [2:0]                  i_cmd,
    input  logic [xkb_pkg::ID_W-1:0]    i_key,
    input  logic [xkb_pkg::ID_W-1:0]    i_rad,
    input  logic [xkb_pkg::CHK_W-1:0]   i_chk,
    input  logic [xkb_pkg::BKT_W-1:0]   i_ld,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [xkb_pkg::WORD_W-1:0]  i_cfg_data,
    output logic                        o_q_push,
    output xkb_pkg::t_cmd               o_q_data,
    input  logic                        i_q_full
);

    logic [xkb_pkg::WORD_W-1:0] r_loc [4];
    logic                       r_fv;
    logic                       r_ph;
    xkb_pkg::t_cmd              r_item;
    logic [5:0]                 r_pos [4];
    logic [3:0]                 r_nz;
    logic [5:0]                 pos [4];
    logic [xkb_pkg::WORD_W-1:0] x;
    logic [xkb_pkg::BKT_W-1:0]  bkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < 4; w++) begin
                r_loc[w] <= '0;
            end
        end else if (i_cfg_we) begin
            r_loc[i_cfg_idx] <= i_cfg_data;
        end
    end

    // per word position of the highest differing bit, word 0 most significant
    always_comb begin
        for (int w = 0; w < 4; w++) begin
            x      = r_loc[w] ^ r_item.key[xkb_pkg::ID_W-1-w*xkb_pkg::WORD_W -: xkb_pkg::WORD_W];
            pos[w] = '0;
            for (int j = 0; j < xkb_pkg::WORD_W; j++) begin
                if (x[j]) begin
                    pos[w] = 6'(j);
                end
            end
        end
    end

    always_comb begin
        bkt = '0;
        for (int w = 3; w >= 0; w--) begin
            if (r_nz[w]) begin
                bkt = {2'(3 - w), r_pos[w]};
            end
        end
    end

    always_comb begin
        o_q_data         = r_item;
        o_q_data.bkt     = bkt;
        o_q_data.self_id = (r_nz == '0);
        o_q_push         = r_fv && r_ph && !i_q_full;
    end

    assign full = r_fv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_ph <= 1'b0;
        end else if (!r_fv) begin
            if (push) begin
                r_fv <= 1'b1;
                r_ph <= 1'b0;
            end
        end else if (!r_ph) begin
            r_ph <= 1'b1;
        end else if (!i_q_full) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_fv && push) begin
            r_item.op      <= xkb_pkg::t_op'(i_cmd);
            r_item.key     <= i_key;
            r_item.rad     <= i_rad;
            r_item.chk     <= i_chk;
            r_item.ld      <= i_ld;
            r_item.bkt     <= '0;
            r_item.self_id <= 1'b0;
        end
        if (r_fv && !r_ph) begin
            for (int w = 0; w < 4; w++) begin
                r_pos[w] <= pos[w];
                r_nz[w]  <= (r_loc[w] !=
                    r_item.key[xkb_pkg::ID_W-1-w*xkb_pkg::WORD_W -: xkb_pkg::WORD_W]);
            end
        end
    end

endmodule

@@ src/xkb_cmdq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xkb_cmdq
// Two-entry queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module xkb_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xkb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output xkb_pkg::t_cmd o_data,
    output logic          o_empty
);

    xkb_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_n;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_n == 2'd2);
    assign o_empty = (r_n == 2'd0);
    assign o_data  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_n <= r_n + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

@@ src/xkb_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xkb_back
// Carries out table commands over the bucket memories and queues the results.
// ---------------------------------------------------------------------------
module xkb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xkb_pkg::t_cmd i_q,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output xkb_pkg::t_res o_res,
    output logic          empty,
    input  logic          pop
);

    localparam int SW = xkb_pkg::SLOT_W;
    localparam int CW = xkb_pkg::CNT_W;

    xkb_pkg::t_bst              r_st, n_st;
    xkb_pkg::t_cmd              r_c, n_c;
    logic [xkb_pkg::BKT_W-1:0]  r_b, n_b;
    logic [CW-1:0]              r_mc, n_mc, r_sc, n_sc, r_i, n_i, nx;
    logic                       r_drop, n_drop, r_shit, n_shit;
    logic [SW-1:0]              r_sm, n_sm, r_smin, n_smin, r_smax, n_smax, slot;
    logic [xkb_pkg::STAMP_W-1:0] r_stmin, n_stmin, r_stmax, n_stmax, r_clk, n_clk;
    xkb_pkg::t_ment             r_ment, n_ment, r_sent, n_sent, ne;
    xkb_pkg::t_res              r_res, n_res, res_d;
    logic [xkb_pkg::NUM_BUCKETS-1:0] r_cv;

    logic                       m_we, s_we, c_we;
    logic [xkb_pkg::ADDR_W-1:0] m_wa, m_ra, s_wa, s_ra;
    logic [xkb_pkg::BKT_W-1:0]  c_ra;
    xkb_pkg::t_ment             m_wd, m_rd;
    xkb_pkg::t_sent             s_wd, s_rd;
    logic [xkb_pkg::CREC_W-1:0] c_wd, c_rd;
    logic                       res_push, res_full;

    xkb_pkg::t_res              r_rq [2];
    logic                       r_rwp, r_rrp;
    logic [1:0]                 r_rn;
    logic                       do_pop;

    xkb_ram #(.W(xkb_pkg::MAIN_W), .D(xkb_pkg::NUM_BUCKETS * xkb_pkg::BUCKET_SIZE)) u_main (
        .i_clk(i_clk), .i_we(m_we), .i_wa(m_wa), .i_wd(m_wd), .i_ra(m_ra), .o_rd(m_rd)
    );

    xkb_ram #(.W(xkb_pkg::SPARE_W), .D(xkb_pkg::NUM_BUCKETS * xkb_pkg::BUCKET_SIZE)) u_spare (
        .i_clk(i_clk), .i_we(s_we), .i_wa(s_wa), .i_wd(s_wd), .i_ra(s_ra), .o_rd(s_rd)
    );

    xkb_ram #(.W(xkb_pkg::CREC_W), .D(xkb_pkg::NUM_BUCKETS)) u_count (
        .i_clk(i_clk), .i_we(c_we), .i_wa(r_b), .i_wd(c_wd), .i_ra(c_ra), .o_rd(c_rd)
    );

    assign res_full = (r_rn == 2'd2);
    assign empty    = (r_rn == 2'd0);
    assign o_res    = r_rq[r_rrp];
    assign do_pop   = pop && !empty;
    assign c_ra     = (i_q.op == xkb_pkg::OP_LIST) ? i_q.ld : i_q.bkt;

    always_comb begin
        n_st = r_st; n_c = r_c; n_b = r_b; n_mc = r_mc; n_sc = r_sc; n_i = r_i;
        n_drop = r_drop; n_shit = r_shit; n_sm = r_sm; n_smin = r_smin; n_smax = r_smax;
        n_stmin = r_stmin; n_stmax = r_stmax; n_clk = r_clk; n_ment = r_ment;
        n_sent = r_sent; n_res = r_res;
        m_we = 1'b0; m_wa = {r_b, r_i[SW-1:0]}; m_wd = r_ment; m_ra = {r_b, r_i[SW-1:0]};
        s_we = 1'b0; s_wa = {r_b, r_i[SW-1:0]}; s_ra = {r_b, r_i[SW-1:0]};
        s_wd = s_rd;
        c_we = 1'b0; c_wd = {r_mc, r_sc};
        res_push = 1'b0; res_d = r_res; o_q_pop = 1'b0;
        nx = r_i + CW'(1);
        ne.id = r_c.key; ne.rad = r_c.rad; ne.chk = r_c.chk;
        slot = '0;

        unique case (r_st)
            xkb_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop    = 1'b1;
                    n_c        = i_q;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_i        = '0;
                    n_shit     = 1'b0;
                    if (i_q.op == xkb_pkg::OP_LIST) begin
                        n_b  = i_q.ld;
                        n_st = xkb_pkg::B_CNT;
                    end else if (i_q.op inside {xkb_pkg::OP_INSERT, xkb_pkg::OP_REMOVE,
                            xkb_pkg::OP_FIND, xkb_pkg::OP_ALIVE, xkb_pkg::OP_DEAD}
                            && !i_q.self_id) begin
                        n_b  = i_q.bkt;
                        n_st = xkb_pkg::B_CNT;
                    end else begin
                        if (i_q.op == xkb_pkg::OP_INSERT) begin
                            n_res.status = xkb_pkg::ST_SELF;
                        end
                        n_st = xkb_pkg::B_OUT;
                    end
                end
            end
            xkb_pkg::B_CNT: begin
                n_mc = r_cv[r_b] ? c_rd[2*CW-1:CW] : '0;
                n_sc = r_cv[r_b] ? c_rd[CW-1:0] : '0;
                if (r_c.op == xkb_pkg::OP_LIST) begin
                    n_st = (n_mc == '0) ? xkb_pkg::B_OUT : xkb_pkg::B_LRD;
                end else begin
                    n_st = xkb_pkg::B_MRD;
                end
            end
            xkb_pkg::B_LRD: begin
                n_st = xkb_pkg::B_LOUT;
            end
            xkb_pkg::B_LOUT: begin
                if (!res_full) begin
                    res_push     = 1'b1;
                    res_d.status = xkb_pkg::ST_TRUE;
                    res_d.inrep  = 1'b0;
                    res_d.id     = m_rd.id;
                    res_d.rad    = m_rd.rad;
                    res_d.chk    = m_rd.chk;
                    res_d.last   = (nx == r_mc);
                    n_i          = nx;
                    n_st         = (nx == r_mc) ? xkb_pkg::B_IDLE : xkb_pkg::B_LRD;
                end
            end
            xkb_pkg::B_MRD: begin
                if (r_i != r_mc) begin
                    n_st = xkb_pkg::B_MCMP;
                end else begin
                    n_i = '0;
                    case (r_c.op)
                        xkb_pkg::OP_INSERT: begin
                            if (r_mc < CW'(xkb_pkg::BUCKET_SIZE)) begin
                                m_we         = 1'b1;
                                m_wa         = {r_b, r_mc[SW-1:0]};
                                m_wd         = ne;
                                n_mc         = r_mc + CW'(1);
                                n_clk        = r_clk + 1'b1;
                                n_res.status = xkb_pkg::ST_ADDED;
                                n_st         = xkb_pkg::B_CWR;
                            end else begin
                                n_st = xkb_pkg::B_SRD;
                            end
                        end
                        xkb_pkg::OP_REMOVE, xkb_pkg::OP_FIND: n_st = xkb_pkg::B_SRD;
                        default: n_st = xkb_pkg::B_OUT;
                    endcase
                end
            end
            xkb_pkg::B_MCMP: begin
                if (m_rd.id == r_c.key) begin
                    n_st = xkb_pkg::B_MSH_RD;
                    case (r_c.op)
                        xkb_pkg::OP_INSERT: begin
                            n_ment       = ne;
                            n_clk        = r_clk + 1'b1;
                            n_res.status = xkb_pkg::ST_UPDATED;
                            n_drop       = 1'b0;
                        end
                        xkb_pkg::OP_REMOVE: begin
                            n_res.status = xkb_pkg::ST_TRUE;
                            n_drop       = 1'b1;
                        end
                        xkb_pkg::OP_FIND: begin
                            n_res.status = xkb_pkg::ST_TRUE;
                            n_res.id     = m_rd.id;
                            n_res.rad    = m_rd.rad;
                            n_res.chk    = m_rd.chk;
                            n_st         = xkb_pkg::B_OUT;
                        end
                        xkb_pkg::OP_ALIVE: begin
                            n_ment = m_rd;
                            if (m_rd.chk != '1) begin
                                n_ment.chk = m_rd.chk + 1'b1;
                            end
                            n_clk        = r_clk + 1'b1;
                            n_res.status = xkb_pkg::ST_TRUE;
                            n_drop       = 1'b0;
                        end
                        default: n_drop = 1'b1;
                    endcase
                end else begin
                    n_i  = nx;
                    n_st = xkb_pkg::B_MRD;
                end
            end
            xkb_pkg::B_MSH_RD: begin
                if (nx < r_mc) begin
                    m_ra = {r_b, nx[SW-1:0]};
                    n_st = xkb_pkg::B_MSH_WR;
                end else if (!r_drop) begin
                    m_we = 1'b1;
                    m_wa = {r_b, SW'(r_mc - CW'(1))};
                    n_st = xkb_pkg::B_CWR;
                end else begin
                    n_mc = r_mc - CW'(1);
                    n_i  = '0;
                    if (r_c.op == xkb_pkg::OP_DEAD && r_sc != '0) begin
                        n_st = xkb_pkg::B_SRD;
                    end else begin
                        n_st = xkb_pkg::B_CWR;
                    end
                end
            end
            xkb_pkg::B_MSH_WR: begin
                m_we = 1'b1;
                m_wd = m_rd;
                n_i  = nx;
                n_st = xkb_pkg::B_MSH_RD;
            end
            xkb_pkg::B_SRD: begin
                if (r_i != r_sc) begin
                    n_st = xkb_pkg::B_SCMP;
                end else begin
                    n_st = xkb_pkg::B_OUT;
                    case (r_c.op)
                        xkb_pkg::OP_INSERT: begin
                            if (r_shit) begin
                                slot = r_sm;
                            end else if (r_sc < CW'(xkb_pkg::BUCKET_SIZE)) begin
                                slot = r_sc[SW-1:0];
                                n_sc = r_sc + CW'(1);
                            end else begin
                                slot = r_smin;
                            end
                            s_we         = 1'b1;
                            s_wa         = {r_b, slot};
                            s_wd.e       = ne;
                            s_wd.st      = r_clk + 1'b1;
                            n_clk        = r_clk + 1'b1;
                            n_res.status = xkb_pkg::ST_REPL;
                            n_st         = xkb_pkg::B_CWR;
                        end
                        xkb_pkg::OP_REMOVE: begin
                            if (r_shit) begin
                                n_res.status = xkb_pkg::ST_TRUE;
                                n_i          = CW'(r_sm);
                                n_st         = xkb_pkg::B_SSH_RD;
                            end
                        end
                        xkb_pkg::OP_FIND: begin
                            if (r_shit) begin
                                n_res.status = xkb_pkg::ST_TRUE;
                                n_res.inrep  = 1'b1;
                                n_res.id     = r_sent.id;
                                n_res.rad    = r_sent.rad;
                                n_res.chk    = r_sent.chk;
                            end
                        end
                        xkb_pkg::OP_DEAD: begin
                            n_i  = CW'(r_smax);
                            n_st = xkb_pkg::B_PRD;
                        end
                        default: n_st = xkb_pkg::B_OUT;
                    endcase
                end
            end
            xkb_pkg::B_SCMP: begin
                if (!r_shit && s_rd.e.id == r_c.key) begin
                    n_shit = 1'b1;
                    n_sm   = r_i[SW-1:0];
                    n_sent = s_rd.e;
                end
                if (r_i == '0 || s_rd.st < r_stmin) begin
                    n_smin  = r_i[SW-1:0];
                    n_stmin = s_rd.st;
                end
                if (r_i == '0 || s_rd.st > r_stmax) begin
                    n_smax  = r_i[SW-1:0];
                    n_stmax = s_rd.st;
                end
                n_i  = nx;
                n_st = xkb_pkg::B_SRD;
            end
            xkb_pkg::B_PRD: begin
                n_st = xkb_pkg::B_PWR;
            end
            xkb_pkg::B_PWR: begin
                m_we         = 1'b1;
                m_wa         = {r_b, r_mc[SW-1:0]};
                m_wd         = s_rd.e;
                n_mc         = r_mc + CW'(1);
                n_clk        = r_clk + 1'b1;
                n_res.status = xkb_pkg::ST_TRUE;
                n_st         = xkb_pkg::B_SSH_RD;
            end
            xkb_pkg::B_SSH_RD: begin
                if (nx < r_sc) begin
                    s_ra = {r_b, nx[SW-1:0]};
                    n_st = xkb_pkg::B_SSH_WR;
                end else begin
                    n_sc = r_sc - CW'(1);
                    n_st = xkb_pkg::B_CWR;
                end
            end
            xkb_pkg::B_SSH_WR: begin
                s_we = 1'b1;
                n_i  = nx;
                n_st = xkb_pkg::B_SSH_RD;
            end
            xkb_pkg::B_CWR: begin
                c_we = 1'b1;
                n_st = xkb_pkg::B_OUT;
            end
            xkb_pkg::B_OUT: begin
                if (!res_full) begin
                    res_push = 1'b1;
                    n_st     = xkb_pkg::B_IDLE;
                end
            end
            default: n_st = xkb_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= xkb_pkg::B_IDLE;
            r_clk <= '0;
            r_cv  <= '0;
            r_rwp <= 1'b0;
            r_rrp <= 1'b0;
            r_rn  <= 2'd0;
        end else begin
            r_st  <= n_st;
            r_clk <= n_clk;
            if (c_we) begin
                r_cv[r_b] <= 1'b1;
            end
            if (res_push) begin
                r_rwp <= !r_rwp;
            end
            if (do_pop) begin
                r_rrp <= !r_rrp;
            end
            r_rn <= r_rn + 2'(res_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c; r_b <= n_b; r_mc <= n_mc; r_sc <= n_sc; r_i <= n_i;
        r_drop <= n_drop; r_shit <= n_shit; r_sm <= n_sm; r_smin <= n_smin;
        r_smax <= n_smax; r_stmin <= n_stmin; r_stmax <= n_stmax;
        r_ment <= n_ment; r_sent <= n_sent; r_res <= n_res;
        if (res_push) begin
            r_rq[r_rwp] <= res_d;
        end
    end

endmodule

@@ src/xor_kbucket_routing_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xor_kbucket_routing_table
// Kademlia style routing table: 256 buckets of 16 main and 16 spare entries.
// ---------------------------------------------------------------------------
// The bucket of a key is the position of the highest bit in which it differs
// from the local id. Commands go through a front stage and a short queue
// into the back, which runs one command at a time over memories with one
// write port and one registered read port: each entry looked at or moved
// takes a read step and then a compare or write step, and a list reads and
// then outputs each entry. Results wait in a two-entry output queue.
// ---------------------------------------------------------------------------
module xor_kbucket_routing_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_key_w0,
    input  logic [63:0] i_key_w1,
    input  logic [63:0] i_key_w2,
    input  logic [63:0] i_key_w3,
    input  logic [63:0] i_radius_w0,
    input  logic [63:0] i_radius_w1,
    input  logic [63:0] i_radius_w2,
    input  logic [63:0] i_radius_w3,
    input  logic [31:0] i_checks_in,
    input  logic [7:0]  i_log_distance,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic        o_in_replacement,
    output logic [63:0] o_node_w0,
    output logic [63:0] o_node_w1,
    output logic [63:0] o_node_w2,
    output logic [63:0] o_node_w3,
    output logic [63:0] o_node_radius_w0,
    output logic [63:0] o_node_radius_w1,
    output logic [63:0] o_node_radius_w2,
    output logic [63:0] o_node_radius_w3,
    output logic [31:0] o_node_checks,
    output logic        o_last_item
);

    xkb_pkg::t_cmd q_in, q_out;
    logic          q_push, q_full, q_pop, q_empty;
    xkb_pkg::t_res res;

    xkb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cmd(i_cmd),
        .i_key({i_key_w0, i_key_w1, i_key_w2, i_key_w3}),
        .i_rad({i_radius_w0, i_radius_w1, i_radius_w2, i_radius_w3}),
        .i_chk(i_checks_in), .i_ld(i_log_distance),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_q_push(q_push), .o_q_data(q_in), .i_q_full(q_full)
    );

    xkb_cmdq u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_data(q_in),
        .o_full(q_full), .i_pop(q_pop), .o_data(q_out), .o_empty(q_empty)
    );

    xkb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q(q_out), .i_q_empty(q_empty),
        .o_q_pop(q_pop), .o_res(res), .empty(empty), .pop(pop)
    );

    assign o_status         = res.status;
    assign o_in_replacement = res.inrep;
    assign o_node_w0        = res.id[255:192];
    assign o_node_w1        = res.id[191:128];
    assign o_node_w2        = res.id[127:64];
    assign o_node_w3        = res.id[63:0];
    assign o_node_radius_w0 = res.rad[255:192];
    assign o_node_radius_w1 = res.rad[191:128];
    assign o_node_radius_w2 = res.rad[127:64];
    assign o_node_radius_w3 = res.rad[63:0];
    assign o_node_checks    = res.chk;
    assign o_last_item      = res.last;

`ifndef SYNTHESIS
    a_inrep_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_in_replacement |-> o_status == 3'(xkb_pkg::ST_TRUE))
        else $error("replacement hit without found status");

    a_update_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_status == 3'(xkb_pkg::ST_ADDED) || o_status == 3'(xkb_pkg::ST_UPDATED)
        || o_status == 3'(xkb_pkg::ST_REPL) || o_status == 3'(xkb_pkg::ST_SELF))
        |-> o_node_checks == '0 && o_node_w0 == '0 && o_last_item)
        else $error("table update result carries entry data");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !full && empty)
        else $error("queues not clear after reset");
`endif

endmodule

@@ test/tb_xor_kbucket_routing_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_xor_kbucket_routing_table
// Self-checking bench for the xor k-bucket routing table. Commands go in
// through the push side with random gaps. Results are popped with random
// stalls and checked field by field against an in-bench table model that
// tracks buckets, spare caches and stamps. The local id is set to several
// values, all zeros and all ones among them, between phases.
// ---------------------------------------------------------------------------
module tb_xor_kbucket_routing_table;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int         POOL_N      = 40;
    localparam int         DRAIN_WAIT  = 150;

    typedef struct {
        logic [255:0] id;
        logic [255:0] rad;
        logic [31:0]  chk;
        logic [63:0]  stamp;
    } t_node_rec;

    typedef struct {
        logic [2:0]   status;
        logic         inrep;
        logic [255:0] id;
        logic [255:0] rad;
        logic [31:0]  chk;
        logic         last;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [2:0]  i_cmd;
    logic [63:0] i_key_w0, i_key_w1, i_key_w2, i_key_w3;
    logic [63:0] i_radius_w0, i_radius_w1, i_radius_w2, i_radius_w3;
    logic [31:0] i_checks_in;
    logic [7:0]  i_log_distance;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status;
    logic        o_in_replacement;
    logic [63:0] o_node_w0, o_node_w1, o_node_w2, o_node_w3;
    logic [63:0] o_node_radius_w0, o_node_radius_w1, o_node_radius_w2, o_node_radius_w3;
    logic [31:0] o_node_checks;
    logic        o_last_item;

    xor_kbucket_routing_table DUT (.*);

    // table model
    logic [255:0] own_id;
    t_node_rec    main_tbl [256][16];
    t_node_rec    spare_tbl[256][16];
    int           main_cnt [256];
    int           spare_cnt[256];
    logic [63:0]  stamp_ctr;

    t_answer      answers_due[$];
    int           mismatches;
    bit           no_idle;
    logic [255:0] key_pool[POOL_N];
    int           pool_bkt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [255:0] rand256();
        logic [255:0] v;
        for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    function automatic bit bucket_of(input logic [255:0] key, output int b);
        logic [255:0] x;
        x = key ^ own_id;
        b = 0;
        for (int i = 255; i >= 0; i--) begin
            if (x[i]) begin
                b = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int scan_main(int b, logic [255:0] key);
        for (int i = 0; i < main_cnt[b]; i++) if (main_tbl[b][i].id == key) return i;
        return -1;
    endfunction

    function automatic int scan_spare(int b, logic [255:0] key);
        for (int i = 0; i < spare_cnt[b]; i++) if (spare_tbl[b][i].id == key) return i;
        return -1;
    endfunction

    function automatic void drop_main(int b, int p);
        for (int i = p; i + 1 < main_cnt[b]; i++) main_tbl[b][i] = main_tbl[b][i+1];
        main_cnt[b]--;
    endfunction

    function automatic void drop_spare(int b, int p);
        for (int i = p; i + 1 < spare_cnt[b]; i++) spare_tbl[b][i] = spare_tbl[b][i+1];
        spare_cnt[b]--;
    endfunction

    function automatic void move_to_tail(int b, int p);
        t_node_rec r;
        r = main_tbl[b][p];
        for (int i = p; i + 1 < main_cnt[b]; i++) main_tbl[b][i] = main_tbl[b][i+1];
        main_tbl[b][main_cnt[b]-1] = r;
    endfunction

    function automatic void expect_answer(logic [2:0] st, logic inrep, t_node_rec r, bit last);
        t_answer a;
        a.status = st;
        a.inrep  = inrep;
        a.id     = r.id;
        a.rad    = r.rad;
        a.chk    = r.chk;
        a.last   = last;
        answers_due.push_back(a);
    endfunction

    function automatic void apply_command(logic [2:0] cmd, logic [255:0] key,
                                          logic [255:0] rad, logic [31:0] chk,
                                          logic [7:0] ld);
        t_node_rec zero_rec, r;
        int b, p, s, n;
        zero_rec = '{default: '0};
        if (cmd == xkb_pkg::OP_LIST) begin
            n = main_cnt[ld];
            if (n == 0) expect_answer(xkb_pkg::ST_FALSE, 1'b0, zero_rec, 1'b1);
            for (int i = 0; i < n; i++) begin
                r = main_tbl[ld][i];
                expect_answer(xkb_pkg::ST_TRUE, 1'b0, r, i + 1 == n);
            end
            return;
        end
        if (cmd == CMD_SPARE_6 || cmd == CMD_SPARE_7) begin
            expect_answer(xkb_pkg::ST_FALSE, 1'b0, zero_rec, 1'b1);
            return;
        end
        if (!bucket_of(key, b)) begin
            expect_answer(cmd == xkb_pkg::OP_INSERT ? xkb_pkg::ST_SELF : xkb_pkg::ST_FALSE,
                          1'b0, zero_rec, 1'b1);
            return;
        end
        r.id  = key;
        r.rad = rad;
        r.chk = chk;
        case (cmd)
            xkb_pkg::OP_INSERT: begin
                p = scan_main(b, key);
                if (p >= 0 || main_cnt[b] < 16) begin
                    stamp_ctr++;
                    r.stamp = stamp_ctr;
                    if (p >= 0) begin
                        main_tbl[b][p] = r;
                        move_to_tail(b, p);
                        expect_answer(xkb_pkg::ST_UPDATED, 1'b0, zero_rec, 1'b1);
                    end else begin
                        main_tbl[b][main_cnt[b]] = r;
                        main_cnt[b]++;
                        expect_answer(xkb_pkg::ST_ADDED, 1'b0, zero_rec, 1'b1);
                    end
                end else begin
                    s = scan_spare(b, key);
                    if (s < 0) begin
                        if (spare_cnt[b] < 16) begin
                            s = spare_cnt[b];
                            spare_cnt[b]++;
                        end else begin
                            s = 0;
                            for (int i = 1; i < spare_cnt[b]; i++)
                                if (spare_tbl[b][i].stamp < spare_tbl[b][s].stamp) s = i;
                        end
                    end
                    stamp_ctr++;
                    r.stamp = stamp_ctr;
                    spare_tbl[b][s] = r;
                    expect_answer(xkb_pkg::ST_REPL, 1'b0, zero_rec, 1'b1);
                end
            end
            xkb_pkg::OP_REMOVE: begin
                p = scan_main(b, key);
                s = scan_spare(b, key);
                if (p >= 0) drop_main(b, p);
                else if (s >= 0) drop_spare(b, s);
                expect_answer((p >= 0 || s >= 0) ? xkb_pkg::ST_TRUE : xkb_pkg::ST_FALSE,
                              1'b0, zero_rec, 1'b1);
            end
            xkb_pkg::OP_FIND: begin
                p = scan_main(b, key);
                s = scan_spare(b, key);
                if (p >= 0) expect_answer(xkb_pkg::ST_TRUE, 1'b0, main_tbl[b][p], 1'b1);
                else if (s >= 0) expect_answer(xkb_pkg::ST_TRUE, 1'b1, spare_tbl[b][s], 1'b1);
                else expect_answer(xkb_pkg::ST_FALSE, 1'b0, zero_rec, 1'b1);
            end
            xkb_pkg::OP_ALIVE: begin
                p = scan_main(b, key);
                if (p >= 0) begin
                    stamp_ctr++;
                    main_tbl[b][p].stamp = stamp_ctr;
                    if (main_tbl[b][p].chk != 32'hFFFF_FFFF) main_tbl[b][p].chk++;
                    move_to_tail(b, p);
                end
                expect_answer(p >= 0 ? xkb_pkg::ST_TRUE : xkb_pkg::ST_FALSE,
                              1'b0, zero_rec, 1'b1);
            end
            default: begin
                p = scan_main(b, key);
                if (p >= 0) drop_main(b, p);
                if (p >= 0 && spare_cnt[b] > 0) begin
                    s = 0;
                    for (int i = 1; i < spare_cnt[b]; i++)
                        if (spare_tbl[b][i].stamp > spare_tbl[b][s].stamp) s = i;
                    r = spare_tbl[b][s];
                    stamp_ctr++;
                    r.stamp = stamp_ctr;
                    main_tbl[b][main_cnt[b]] = r;
                    main_cnt[b]++;
                    drop_spare(b, s);
                    expect_answer(xkb_pkg::ST_TRUE, 1'b0, zero_rec, 1'b1);
                end else begin
                    expect_answer(xkb_pkg::ST_FALSE, 1'b0, zero_rec, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one item and hold it until it is taken
    task automatic send_item(logic [2:0] cmd, logic [255:0] key, logic [255:0] rad,
                             logic [31:0] chk, logic [7:0] ld);
        int gap;
        push           <= 1'b1;
        i_cmd          <= cmd;
        {i_key_w0, i_key_w1, i_key_w2, i_key_w3} <= key;
        {i_radius_w0, i_radius_w1, i_radius_w2, i_radius_w3} <= rad;
        i_checks_in    <= chk;
        i_log_distance <= ld;
        do @(posedge i_clk); while (full);
        apply_command(cmd, key, rad, chk, ld);
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (answers_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_own_id(logic [255:0] v);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(i);
            i_cfg_data <= v[255 - 64*i -: 64];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        own_id = v;
    endtask

    function automatic logic [255:0] key_in_bucket(int b);
        logic [255:0] x;
        x = rand256();
        x = x & ((256'd1 << b) - 256'd1);
        x[b] = 1'b1;
        return own_id ^ x;
    endfunction

    function automatic void fill_pool();
        pool_bkt = $urandom_range(6, 255);
        for (int i = 0; i < POOL_N; i++) key_pool[i] = key_in_bucket(pool_bkt);
    endfunction

    task automatic test_self_and_unused();
        send_item(xkb_pkg::OP_INSERT, own_id, rand256(), $urandom, 8'h00);
        send_item(xkb_pkg::OP_REMOVE, own_id, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_FIND,   own_id, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_ALIVE,  own_id, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_DEAD,   own_id, '0, '0, 8'h00);
        send_item(CMD_SPARE_6, rand256(), rand256(), $urandom, 8'hFF);
        send_item(CMD_SPARE_7, '1, '1, '1, 8'hFF);
        send_item(xkb_pkg::OP_LIST,   '0, '0, '0, 8'hFF);
    endtask

    task automatic test_extremes();
        logic [255:0] k0;
        k0 = own_id ^ 256'd1;
        send_item(xkb_pkg::OP_INSERT, '1, '1, 32'hFFFF_FFFE, 8'h00);
        send_item(xkb_pkg::OP_ALIVE,  '1, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_ALIVE,  '1, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_FIND,   '1, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_INSERT, k0, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_INSERT, k0, rand256(), $urandom, 8'h00);
        send_item(xkb_pkg::OP_LIST,   '0, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_LIST,   '0, '0, '0, 8'hFF);
        send_item(xkb_pkg::OP_DEAD,   k0, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_REMOVE, '1, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_REMOVE, '1, '0, '0, 8'h00);
        send_item(xkb_pkg::OP_FIND,   k0, '0, '0, 8'h00);
    endtask

    task automatic test_random_traffic(int n_items);
        int r;
        logic [2:0]   cmd;
        logic [255:0] key;
        logic [7:0]   ld;
        fill_pool();
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45)      cmd = xkb_pkg::OP_INSERT;
            else if (r < 55) cmd = xkb_pkg::OP_REMOVE;
            else if (r < 70) cmd = xkb_pkg::OP_FIND;
            else if (r < 80) cmd = xkb_pkg::OP_ALIVE;
            else if (r < 90) cmd = xkb_pkg::OP_DEAD;
            else if (r < 97) cmd = xkb_pkg::OP_LIST;
            else             cmd = 3'($urandom_range(6, 7));
            r = $urandom_range(0, 99);
            if (r < 88)      key = key_pool[$urandom_range(0, POOL_N - 1)];
            else if (r < 92) key = own_id;
            else             key = rand256();
            ld = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(pool_bkt);
            send_item(cmd, key, rand256(), $urandom, ld);
        end
        no_idle = 1'b0;
    endtask

    // result side: random stalls, compare against oldest expectation
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop        <= 1'b0;
            stall_left <= 0;
        end else begin
            if (stall_left > 0) begin
                pop        <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                pop        <= 1'b1;
                stall_left <= pick_gap();
            end
            if (pop && !empty) begin
                t_answer a;
                t_answer got;
                got.status = o_status;
                got.inrep  = o_in_replacement;
                got.id     = {o_node_w0, o_node_w1, o_node_w2, o_node_w3};
                got.rad    = {o_node_radius_w0, o_node_radius_w1,
                              o_node_radius_w2, o_node_radius_w3};
                got.chk    = o_node_checks;
                got.last   = o_last_item;
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: status %0d last %0d", got.status, got.last);
                end else begin
                    a = answers_due.pop_front();
                    if (got.status !== a.status || got.inrep !== a.inrep
                            || got.id !== a.id || got.rad !== a.rad
                            || got.chk !== a.chk || got.last !== a.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp st %0d rep %0d chk %h last %0d",
                                     a.status, a.inrep, a.chk, a.last);
                            $display("          got st %0d rep %0d chk %h last %0d",
                                     got.status, got.inrep, got.chk, got.last);
                            $display("          exp id %h rad %h", a.id, a.rad);
                            $display("          got id %h rad %h", got.id, got.rad);
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        push           = 1'b0;
        i_cmd          = xkb_pkg::OP_INSERT;
        {i_key_w0, i_key_w1, i_key_w2, i_key_w3} = '0;
        {i_radius_w0, i_radius_w1, i_radius_w2, i_radius_w3} = '0;
        i_checks_in    = '0;
        i_log_distance = '0;
        mismatches     = 0;
        no_idle        = 1'b0;
        own_id         = '0;
        stamp_ctr      = '0;
        for (int b = 0; b < 256; b++) begin
            main_cnt[b]  = 0;
            spare_cnt[b] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_own_id('0);
        test_self_and_unused();
        test_extremes();
        drain();

        set_own_id('1);
        test_random_traffic(70);
        test_extremes();
        drain();

        set_own_id(rand256());
        test_random_traffic(60);
        drain();

        set_own_id(rand256());
        test_self_and_unused();
        test_random_traffic(40);
        drain();

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
